// ===== rtl/pbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbb_pkg: shared definitions for the page bitmap blitter
// Geometry constants, operation codes and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbb_pkg;

    // Framebuffer geometry
    localparam int FB_COLUMNS   = 128;
    localparam int FB_PAGES     = 8;
    localparam int FRAME_BYTES  = FB_COLUMNS * FB_PAGES;
    // Sprite store size, a power of two so the index wraps by truncation
    localparam int SPRITE_BYTES = 1024;

    localparam int FB_AW  = $clog2(FRAME_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);

    // Page counters: start page up to 31 plus up to 33 pages walked
    localparam int PAGE_W = 7;
    // Column position x + c, up to 510
    localparam int COL_W  = 9;
    // Framebuffer row base (page * FB_COLUMNS), for start pages up to 31
    localparam int ROW_W  = 16;

    localparam int ADDR_W  = 10;
    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] TOUCH_MAX = 11'h7ff;

    localparam logic [7:0] BYTE_ONES = 8'hff;
    localparam logic [2:0] ROW_MASK  = 3'b111;

    // Operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BLIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // word taken from the input channel
        logic clear_step;  // zero one framebuffer byte of the clearing pass
        logic rd_a;        // read frame byte and current sprite byte
        logic rd_b;        // read sprite byte of the page above
        logic wr;          // merge and write back, next column
        logic next_page;   // advance to the next page
        logic out_zero;    // load output register with an all-zero result
        logic out_result;  // load output register with the read or blit result
    } pbb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  in_op;       // operation of the word on the input channel
        logic page_go;     // current page is inside the blit and the screen
        logic col_go;      // current column is inside the blit and the screen
        logic clear_last;  // clearing pass is at its last byte
    } pbb_status_t;

endpackage

// ===== rtl/pbb_if.sv =====
// ----------------------------------------------------------------------------
// pbb_if: handshake channels of the page bitmap blitter
// Request channel (one operation per word) and response channel (one
// result per word), each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface pbb_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     operation;
    logic [pbb_pkg::ADDR_W-1:0]     address;
    logic [7:0]                     data;
    logic [7:0]                     pos_x;
    logic [7:0]                     pos_y;
    logic [7:0]                     sprite_width;
    logic [7:0]                     sprite_height;
    logic                           mask_mode;

    modport source (
        output valid, operation, address, data, pos_x, pos_y,
               sprite_width, sprite_height, mask_mode,
        input  ready
    );
    modport sink (
        input  valid, operation, address, data, pos_x, pos_y,
               sprite_width, sprite_height, mask_mode,
        output ready
    );
endinterface

interface pbb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     read_data;
    logic [pbb_pkg::COUNT_W-1:0]    bytes_touched;

    modport source (
        output valid, read_data, bytes_touched,
        input  ready
    );
    modport sink (
        input  valid, read_data, bytes_touched,
        output ready
    );
endinterface

// ===== rtl/page_bitmap_blitter.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_blitter: page-organized monochrome framebuffer with sprite blit
// Loads sprite bytes, reads and writes framebuffer bytes and blits sprites
// with draw (OR) or mask (AND) merge, clipped at the screen edges.
//
//   channel | dir | words
//   --------+-----+------------------------------------------------------
//   req     | in  | operation, address, data, pos_x, pos_y, sprite size, mode
//   rsp     | out | read_data, bytes_touched (one word per request)
//
// Load and write answer from IDLE; a read answers from FINISH after the
// registered framebuffer read. A blit runs COL, RD_B and WR per visited byte
// (frame read, second sprite read, write back; the RAMs have one read port),
// plus PAGE and a closing COL per visited page, then FINISH. A clearing pass
// after reset zeroes the framebuffer, one byte per cycle; no request is taken during it.
// A new request is taken while a response waits, as long as the response
// register is free or being drained; a stalled response holds the block.
// ----------------------------------------------------------------------------
module page_bitmap_blitter (
    input  logic clk,
    input  logic rst_n,
    pbb_req_if.sink   req,
    pbb_rsp_if.source rsp
);

    pbb_pkg::pbb_cmd_t    cmd;
    pbb_pkg::pbb_status_t status;

    pbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pbb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (req.operation),
        .address       (req.address),
        .data          (req.data),
        .pos_x         (req.pos_x),
        .pos_y         (req.pos_y),
        .sprite_width  (req.sprite_width),
        .sprite_height (req.sprite_height),
        .mask_mode     (req.mask_mode),
        .read_data     (rsp.read_data),
        .bytes_touched (rsp.bytes_touched)
    );

endmodule

// ===== rtl/pbb_ram.sv =====
// ----------------------------------------------------------------------------
// pbb_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// while no read is enabled.
// ----------------------------------------------------------------------------
module pbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pbb_datapath.sv =====
// ----------------------------------------------------------------------------
// pbb_datapath: stores, counters and byte merge of the blitter
// Holds the framebuffer and sprite store, the blit walk registers, the
// shift/merge of one byte and the output word register.
// ----------------------------------------------------------------------------
module pbb_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pbb_pkg::pbb_cmd_t            cmd,
    output pbb_pkg::pbb_status_t         status,
    // request payload
    input  logic [1:0]                   operation,
    input  logic [pbb_pkg::ADDR_W-1:0]   address,
    input  logic [7:0]                   data,
    input  logic [7:0]                   pos_x,
    input  logic [7:0]                   pos_y,
    input  logic [7:0]                   sprite_width,
    input  logic [7:0]                   sprite_height,
    input  logic                         mask_mode,
    // response payload
    output logic [7:0]                   read_data,
    output logic [pbb_pkg::COUNT_W-1:0]  bytes_touched
);

    // Item registers
    pbb_pkg::op_t                  op_reg;
    logic                          addr_ok_reg;
    logic [7:0]                    x_reg;
    logic [7:0]                    w_reg;
    logic [2:0]                    off_reg;
    logic                          mask_reg;
    logic [pbb_pkg::PAGE_W-1:0]    start_reg;
    logic [pbb_pkg::PAGE_W-1:0]    pages_reg;
    logic [pbb_pkg::PAGE_W-1:0]    total_reg;

    // Walk registers
    logic [pbb_pkg::PAGE_W-1:0]    page_reg;
    logic [7:0]                    c_reg;
    logic [pbb_pkg::ROW_W-1:0]     row_base_reg;
    logic [pbb_pkg::SPR_AW-1:0]    spr_base_reg;
    logic [pbb_pkg::SPR_AW-1:0]    spr_prev_base_reg;
    logic [7:0]                    cur_byte_reg;
    logic [7:0]                    frame_byte_reg;
    logic [pbb_pkg::COUNT_W-1:0]   touched_reg;
    logic [pbb_pkg::FB_AW-1:0]     clear_cnt_reg;

    // Output word
    logic [7:0]                    read_data_reg;
    logic [pbb_pkg::COUNT_W-1:0]   bytes_touched_reg;

    // RAM ports
    logic                          fb_we;
    logic [pbb_pkg::FB_AW-1:0]     fb_waddr;
    logic [7:0]                    fb_wdata;
    logic                          fb_re;
    logic [pbb_pkg::FB_AW-1:0]     fb_raddr;
    logic [7:0]                    fb_rdata;
    logic                          spr_we;
    logic                          spr_re;
    logic [pbb_pkg::SPR_AW-1:0]    spr_raddr;
    logic [7:0]                    spr_rdata;

    // Combinational helpers
    logic                          in_addr_ok;
    logic [pbb_pkg::FB_AW-1:0]     in_fb_addr;
    logic [pbb_pkg::PAGE_W-1:0]    in_pages;
    logic [pbb_pkg::COL_W-1:0]     col;
    logic [pbb_pkg::PAGE_W-1:0]    abs_page;
    logic [pbb_pkg::FB_AW-1:0]     fb_addr;
    logic [pbb_pkg::SPR_AW-1:0]    cur_idx;
    logic [pbb_pkg::SPR_AW-1:0]    prev_idx;
    logic                          hit_cur;
    logic                          hit_prev;
    logic [3:0]                    back_shift;
    logic [7:0]                    merged;
    logic [7:0]                    b_cur;
    logic [7:0]                    b_prev;

    // Request decode
    assign in_addr_ok = ({22'd0, address} < 32'(pbb_pkg::FRAME_BYTES));
    assign in_fb_addr = pbb_pkg::FB_AW'(address);
    assign in_pages   = pbb_pkg::PAGE_W'(sprite_height[7:3])
                      + pbb_pkg::PAGE_W'(|(sprite_height[2:0]));

    // Walk position
    assign col      = pbb_pkg::COL_W'(x_reg) + pbb_pkg::COL_W'(c_reg);
    assign abs_page = start_reg + page_reg;
    assign fb_addr  = pbb_pkg::FB_AW'(row_base_reg + pbb_pkg::ROW_W'(col));
    assign cur_idx  = spr_base_reg + pbb_pkg::SPR_AW'(c_reg);
    assign prev_idx = spr_prev_base_reg + pbb_pkg::SPR_AW'(c_reg);

    // Status
    assign status.in_op      = pbb_pkg::op_t'(operation);
    assign status.page_go    = (page_reg < total_reg)
                             && (abs_page < pbb_pkg::PAGE_W'(pbb_pkg::FB_PAGES));
    assign status.col_go     = (c_reg < w_reg)
                             && (col < pbb_pkg::COL_W'(pbb_pkg::FB_COLUMNS));
    assign status.clear_last = (clear_cnt_reg == pbb_pkg::FB_AW'(pbb_pkg::FRAME_BYTES - 1));

    // Byte merge: own page shifted down, page above spills in
    assign hit_cur    = (page_reg < pages_reg);
    assign hit_prev   = (page_reg != '0) && (off_reg != 3'd0);
    assign back_shift = 4'd8 - {1'b0, off_reg};
    assign b_cur      = 8'(cur_byte_reg << off_reg);
    assign b_prev     = spr_rdata >> back_shift;

    always_comb
    begin
        merged = frame_byte_reg;
        if (hit_cur)
        begin
            if (mask_reg)
            begin
                merged = merged & (b_cur | ~8'(pbb_pkg::BYTE_ONES << off_reg));
            end
            else
            begin
                merged = merged | b_cur;
            end
        end
        if (hit_prev)
        begin
            if (mask_reg)
            begin
                merged = merged & (b_prev | ~(pbb_pkg::BYTE_ONES >> back_shift));
            end
            else
            begin
                merged = merged | b_prev;
            end
        end
    end

    // Framebuffer port select
    always_comb
    begin
        fb_we    = 1'b0;
        fb_waddr = clear_cnt_reg;
        fb_wdata = 8'd0;
        if (cmd.clear_step)
        begin
            fb_we = 1'b1;
        end
        else if (cmd.accept && (operation == pbb_pkg::OP_WRITE))
        begin
            fb_we    = in_addr_ok;
            fb_waddr = in_fb_addr;
            fb_wdata = data;
        end
        else if (cmd.wr)
        begin
            fb_we    = hit_cur || hit_prev;
            fb_waddr = fb_addr;
            fb_wdata = merged;
        end
    end

    assign fb_re    = (cmd.accept && (operation == pbb_pkg::OP_READ)) || cmd.rd_a;
    assign fb_raddr = cmd.rd_a ? fb_addr : in_fb_addr;

    // Sprite port select
    assign spr_we    = cmd.accept && (operation == pbb_pkg::OP_LOAD);
    assign spr_re    = cmd.rd_a || cmd.rd_b;
    assign spr_raddr = cmd.rd_b ? prev_idx : cur_idx;

    pbb_ram #(
        .WIDTH (8),
        .DEPTH (pbb_pkg::FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .re    (fb_re),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    pbb_ram #(
        .WIDTH (8),
        .DEPTH (pbb_pkg::SPRITE_BYTES)
    ) u_sprite_ram (
        .clk   (clk),
        .we    (spr_we),
        .waddr (pbb_pkg::SPR_AW'(address)),
        .wdata (data),
        .re    (spr_re),
        .raddr (spr_raddr),
        .rdata (spr_rdata)
    );

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Item capture and blit walk
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg            <= pbb_pkg::op_t'(operation);
            addr_ok_reg       <= in_addr_ok;
            x_reg             <= pos_x;
            w_reg             <= sprite_width;
            off_reg           <= pos_y[2:0] & pbb_pkg::ROW_MASK;
            mask_reg          <= mask_mode;
            start_reg         <= pbb_pkg::PAGE_W'(pos_y[7:3]);
            pages_reg         <= in_pages;
            total_reg         <= in_pages + pbb_pkg::PAGE_W'(|(pos_y[2:0]));
            page_reg          <= '0;
            c_reg             <= '0;
            row_base_reg      <= pbb_pkg::ROW_W'(pos_y[7:3])
                               * pbb_pkg::ROW_W'(pbb_pkg::FB_COLUMNS);
            spr_base_reg      <= '0;
            spr_prev_base_reg <= '0;
            touched_reg       <= '0;
        end
        // frame and own sprite byte arrive in the cycle after rd_a
        if (cmd.rd_b)
        begin
            frame_byte_reg <= fb_rdata;
            cur_byte_reg   <= spr_rdata;
        end
        if (cmd.wr)
        begin
            c_reg <= c_reg + 8'd1;
            if ((hit_cur || hit_prev) && (touched_reg != pbb_pkg::TOUCH_MAX))
            begin
                touched_reg <= touched_reg + 1'b1;
            end
        end
        if (cmd.next_page)
        begin
            page_reg          <= page_reg + 1'b1;
            c_reg             <= '0;
            row_base_reg      <= row_base_reg + pbb_pkg::ROW_W'(pbb_pkg::FB_COLUMNS);
            spr_prev_base_reg <= spr_base_reg;
            spr_base_reg      <= spr_base_reg + pbb_pkg::SPR_AW'(w_reg);
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_zero)
        begin
            read_data_reg     <= 8'd0;
            bytes_touched_reg <= '0;
        end
        else if (cmd.out_result)
        begin
            if (op_reg == pbb_pkg::OP_READ)
            begin
                read_data_reg     <= addr_ok_reg ? fb_rdata : 8'd0;
                bytes_touched_reg <= '0;
            end
            else
            begin
                read_data_reg     <= 8'd0;
                bytes_touched_reg <= touched_reg;
            end
        end
    end

    assign read_data     = read_data_reg;
    assign bytes_touched = bytes_touched_reg;

endmodule

// ===== rtl/pbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbb_ctrl: sequencer of the page bitmap blitter
// Runs the clearing pass, takes request words, steps a blit through its
// pages and columns and owns the response valid flag.
// ----------------------------------------------------------------------------
module pbb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pbb_pkg::pbb_status_t  status,
    output pbb_pkg::pbb_cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_PAGE   = 7'b0000100,
        ST_COL    = 7'b0001000,
        ST_RD_B   = 7'b0010000,
        ST_WR     = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    // Output register can take a word when empty or draining now
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.accept     = accept;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (status.in_op)
                        pbb_pkg::OP_BLIT:
                        begin
                            state_next = ST_PAGE;
                        end
                        pbb_pkg::OP_READ:
                        begin
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            cmd.out_zero   = 1'b1;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_PAGE:
            begin
                state_next = status.page_go ? ST_COL : ST_FINISH;
            end
            ST_COL:
            begin
                if (status.col_go)
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = ST_RD_B;
                end
                else
                begin
                    cmd.next_page = 1'b1;
                    state_next    = ST_PAGE;
                end
            end
            ST_RD_B:
            begin
                cmd.rd_b   = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_COL;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_result = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
